// File: hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, constants and index helpers shared by the work-stealing deque.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int DEPTH    = 64;
	localparam int HANDLE_W = 32;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int IDX_W    = $clog2(2 * DEPTH);
	localparam int LIMIT_W  = 7;
	localparam int OCC_W    = 7;
	localparam int TASK_W   = 32;
	localparam int CMP_W    = (IDX_W > LIMIT_W) ? IDX_W + 1 : LIMIT_W + 1;

	localparam logic [IDX_W:0]     SPAN        = (IDX_W + 1)'(2 * DEPTH);
	localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(2 * DEPTH - 1);
	localparam logic [IDX_W-1:0]   DEPTH_IDX   = IDX_W'(DEPTH);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_STEAL = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [TASK_W-1:0] task_handle;
	} in_item_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_out;
		logic [1:0]        status;
		logic [OCC_W-1:0]  occupancy;
	} out_item_t;

	typedef struct packed {
		logic                mem_we;
		logic [ADDR_W-1:0]   waddr;
		logic [HANDLE_W-1:0] wdata;
		logic                mem_re;
		logic [ADDR_W-1:0]   raddr;
		logic                take;
		logic [1:0]          status;
		logic [OCC_W-1:0]    occupancy;
	} ctl_t;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
		return (v == LAST_IDX) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v);
		return (v == '0) ? LAST_IDX : v - 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] v);
		logic [IDX_W-1:0] t;
		t = (v >= DEPTH_IDX) ? v - DEPTH_IDX : v;
		return t[ADDR_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] held_count(input logic [IDX_W-1:0] b,
			input logic [IDX_W-1:0] t);
		logic [IDX_W:0] d;
		d = {1'b0, b} - {1'b0, t};
		if (d[IDX_W]) begin
			d = d + SPAN;
		end
		return d[IDX_W-1:0];
	endfunction

endpackage

// File: hdl/wsd_ram.sv
// ----------------------------------------------------------------------------
// wsd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wsd_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/wsd_ctrl.sv
// ----------------------------------------------------------------------------
// wsd_ctrl
// Top/bottom indices and capacity limit; decodes each item into a store
// access and its status.
// ----------------------------------------------------------------------------
module wsd_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  wsd_pkg::in_item_t            item,
	input  logic                         cfg_wr_en,
	input  logic [wsd_pkg::LIMIT_W-1:0]  cfg_wr_data,
	output wsd_pkg::ctl_t                ctl
);

	logic [wsd_pkg::IDX_W-1:0]   top_q, bot_q, top_n, bot_n;
	logic [wsd_pkg::IDX_W-1:0]   held, b_dec, held_after;
	logic [wsd_pkg::LIMIT_W-1:0] limit_q;
	logic                        full, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			bot_q   <= '0;
			limit_q <= wsd_pkg::LIMIT_RESET;
		end else begin
			if (accept) begin
				top_q <= top_n;
				bot_q <= bot_n;
			end
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
		end
	end

	always_comb begin
		held  = wsd_pkg::held_count(bot_q, top_q);
		b_dec = wsd_pkg::wrap_dec(bot_q);
		empty = (held == '0);
		full  = (wsd_pkg::CMP_W'(held) >= wsd_pkg::CMP_W'(limit_q))
			|| (held == wsd_pkg::DEPTH_IDX);
		top_n = top_q;
		bot_n = bot_q;
		ctl   = '0;
		ctl.waddr  = wsd_pkg::slot(bot_q);
		ctl.wdata  = wsd_pkg::HANDLE_W'(item.task_handle);
		ctl.raddr  = wsd_pkg::slot(top_q);
		ctl.status = wsd_pkg::STAT_OK;
		case (item.req_type)
			wsd_pkg::REQ_PUSH: begin
				if (full) begin
					ctl.status = wsd_pkg::STAT_FULL;
				end else begin
					ctl.mem_we = 1'b1;
					bot_n      = wsd_pkg::wrap_inc(bot_q);
				end
			end
			wsd_pkg::REQ_POP: begin
				if (empty) begin
					ctl.status = wsd_pkg::STAT_EMPTY;
				end else begin
					ctl.mem_re = 1'b1;
					ctl.take   = 1'b1;
					ctl.raddr  = wsd_pkg::slot(b_dec);
					// last entry: top advances, bottom stays
					if (held == wsd_pkg::IDX_W'(1)) begin
						top_n = wsd_pkg::wrap_inc(top_q);
					end else begin
						bot_n = b_dec;
					end
				end
			end
			wsd_pkg::REQ_STEAL: begin
				if (empty) begin
					ctl.status = wsd_pkg::STAT_EMPTY;
				end else begin
					ctl.mem_re = 1'b1;
					ctl.take   = 1'b1;
					top_n      = wsd_pkg::wrap_inc(top_q);
				end
			end
			default: begin
			end
		endcase
		held_after    = wsd_pkg::held_count(bot_n, top_n);
		ctl.occupancy = wsd_pkg::OCC_W'(held_after);
		ctl.mem_we    = ctl.mem_we & accept;
		ctl.mem_re    = ctl.mem_re & accept;
	end

endmodule

// File: hdl/work_stealing_deque.sv
// ----------------------------------------------------------------------------
// work_stealing_deque
// Chase-Lev style deque of task handles in a ring RAM; push/pop at bottom,
// steal at top, capacity limit register.
// Result path: the accepted item enters the read stage, then the output register holds the result.
// Throughput: one item per cycle while the output is not stalled; store read at accept, result registered.
// in_stall rises only with an item in the read stage behind a stalled output.
// Reset clears indices, pipeline valids and sets the limit to 64.
// The entry RAM is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
module work_stealing_deque (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  wsd_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output wsd_pkg::out_item_t           out_item,
	input  logic                         cfg_wr_en,
	input  logic [wsd_pkg::LIMIT_W-1:0]  cfg_wr_data
);

	wsd_pkg::ctl_t              ctl;
	logic                       accept, advance;
	logic [wsd_pkg::HANDLE_W-1:0] rdata;

	logic                       valid_s1;
	logic                       take_s1;
	logic [1:0]                 status_s1;
	logic [wsd_pkg::OCC_W-1:0]  occ_s1;
	logic                       out_valid_q;
	wsd_pkg::out_item_t         out_item_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	wsd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (in_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.ctl        (ctl)
	);

	wsd_ram #(
		.ADDR_W(wsd_pkg::ADDR_W),
		.DATA_W(wsd_pkg::HANDLE_W)
	) u_ram (
		.clk  (clk),
		.we   (ctl.mem_we),
		.waddr(ctl.waddr),
		.wdata(ctl.wdata),
		.re   (ctl.mem_re),
		.raddr(ctl.raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			take_s1   <= ctl.take;
			status_s1 <= ctl.status;
			occ_s1    <= ctl.occupancy;
		end
		if (advance) begin
			out_item_q.task_out  <= take_s1 ? wsd_pkg::TASK_W'(rdata) : '0;
			out_item_q.status    <= status_s1;
			out_item_q.occupancy <= occ_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
